// ===== src/bpf_pkg.sv =====
// Shared types and codes for the Bezier path follower.
package bpf_pkg;

	typedef struct packed {
		logic [2:0]         action;
		logic [5:0]         index;
		logic signed [31:0] vec_x;
		logic signed [31:0] vec_y;
		logic signed [31:0] vec_z;
		logic [31:0]        seg_length;
		logic [15:0]        time_step;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] tan_x;
		logic signed [31:0] tan_y;
		logic signed [31:0] tan_z;
		logic [5:0]         segment_now;
		logic [15:0]        param_now;
	} out_item_t;

	localparam logic [2:0] ACT_POINT = 3'd0;
	localparam logic [2:0] ACT_IN    = 3'd1;
	localparam logic [2:0] ACT_OUT   = 3'd2;
	localparam logic [2:0] ACT_LEN   = 3'd3;
	localparam logic [2:0] ACT_TICK  = 3'd4;

	localparam logic [1:0] CFG_SPEED   = 2'd0;
	localparam logic [1:0] CFG_ENABLED = 2'd1;
	localparam logic [1:0] CFG_SEGCNT  = 2'd2;

	// multiplier operand selects
	localparam logic [3:0] M_NONE = 4'd0;
	localparam logic [3:0] M_DIST = 4'd1;
	localparam logic [3:0] M_REM  = 4'd2;
	localparam logic [3:0] M_S2   = 4'd3;
	localparam logic [3:0] M_SQ   = 4'd4;
	localparam logic [3:0] M_Q2   = 4'd5;
	localparam logic [3:0] M_S3   = 4'd6;
	localparam logic [3:0] M_T1   = 4'd7;
	localparam logic [3:0] M_T2   = 4'd8;
	localparam logic [3:0] M_Q3   = 4'd9;
	localparam logic [3:0] M_PB   = 4'd10;
	localparam logic [3:0] M_TW   = 4'd11;

	// product destinations
	localparam logic [3:0] D_NONE = 4'd0;
	localparam logic [3:0] D_DIST = 4'd1;
	localparam logic [3:0] D_REM  = 4'd2;
	localparam logic [3:0] D_S2   = 4'd3;
	localparam logic [3:0] D_SQ   = 4'd4;
	localparam logic [3:0] D_Q2   = 4'd5;
	localparam logic [3:0] D_B0   = 4'd6;
	localparam logic [3:0] D_B1   = 4'd7;
	localparam logic [3:0] D_B2   = 4'd8;
	localparam logic [3:0] D_B3   = 4'd9;
	localparam logic [3:0] D_ACC0 = 4'd10;
	localparam logic [3:0] D_ACC  = 4'd11;
	localparam logic [3:0] D_POS  = 4'd12;
	localparam logic [3:0] D_TAN  = 4'd13;

	localparam logic [4:0] EVAL_LAST = 5'd29;

	typedef struct packed {
		logic [3:0] sel;
		logic [3:0] dst;
		logic [1:0] j;
		logic [1:0] k;
	} mul_op_t;

	typedef struct packed {
		logic    accept;
		logic    start;
		mul_op_t op;
		logic    len_latch;
		logic    walk_step;
		logic    rem_load;
		logic    div_fwd;
		logic    div_back;
		logic    div_step;
		logic    div_fin;
		logic    p_max;
		logic    p_zero;
		logic    rd_next;
		logic    cap_a;
		logic    cap_b;
		logic    load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic enabled;
		logic gt;
		logic ge;
		logic len_zero;
		logic back_full;
		logic steps_done;
		logic div_last;
	} dp_stat_t;

endpackage

// ===== src/bpf_if.sv =====
// Request channel interfaces for the path follower.
interface bpf_in_if;
	logic               valid;
	logic               ready;
	bpf_pkg::in_item_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bpf_out_if;
	logic               valid;
	logic               ready;
	bpf_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/bpf_ram.sv =====
// Generic single write, single read RAM with registered read data.
module bpf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== src/bpf_ctrl.sv =====
// Controller state machine: sequences walk, divide, knot fetch and evaluation.
module bpf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          in_action,
	output logic                out_valid,
	input  logic                out_ready,
	output bpf_pkg::ctrl_cmd_t  cmd,
	input  bpf_pkg::dp_stat_t   stat
);
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DIST = 4'd1;
	localparam logic [3:0] ST_LEN  = 4'd2;
	localparam logic [3:0] ST_WAIT = 4'd3;
	localparam logic [3:0] ST_CMP  = 4'd4;
	localparam logic [3:0] ST_WRD  = 4'd5;
	localparam logic [3:0] ST_WLD  = 4'd6;
	localparam logic [3:0] ST_WCHK = 4'd7;
	localparam logic [3:0] ST_DIV  = 4'd8;
	localparam logic [3:0] ST_DIVF = 4'd9;
	localparam logic [3:0] ST_RDA  = 4'd10;
	localparam logic [3:0] ST_RDB  = 4'd11;
	localparam logic [3:0] ST_RDC  = 4'd12;
	localparam logic [3:0] ST_EVAL = 4'd13;
	localparam logic [3:0] ST_OUT  = 4'd14;

	localparam logic [4:0] EVAL_END = bpf_pkg::EVAL_LAST;

	logic [3:0] state_q, state_nx;
	logic [4:0] pc_q;
	logic       out_valid_q;

	// evaluation program: weights, then 4 position and 3 tangent products per axis
	function automatic bpf_pkg::mul_op_t eval_op(input logic [4:0] pc);
		logic [4:0]       r;
		bpf_pkg::mul_op_t o;
		o = '{sel: bpf_pkg::M_NONE, dst: bpf_pkg::D_NONE, j: 2'd0, k: 2'd0};
		r = 5'd0;
		if (pc < 5'd7) begin
			unique case (pc[2:0])
				3'd0: begin o.sel = bpf_pkg::M_S2; o.dst = bpf_pkg::D_S2; end
				3'd1: begin o.sel = bpf_pkg::M_SQ; o.dst = bpf_pkg::D_SQ; end
				3'd2: begin o.sel = bpf_pkg::M_Q2; o.dst = bpf_pkg::D_Q2; end
				3'd3: begin o.sel = bpf_pkg::M_S3; o.dst = bpf_pkg::D_B0; end
				3'd4: begin o.sel = bpf_pkg::M_T1; o.dst = bpf_pkg::D_B1; end
				3'd5: begin o.sel = bpf_pkg::M_T2; o.dst = bpf_pkg::D_B2; end
				default: begin o.sel = bpf_pkg::M_Q3; o.dst = bpf_pkg::D_B3; end
			endcase
		end else if (pc >= 5'd8 && pc < 5'd20) begin
			r = pc - 5'd8;
			o.sel = bpf_pkg::M_PB;
			o.k = r[3:2];
			o.j = r[1:0];
			if (r[1:0] == 2'd0) o.dst = bpf_pkg::D_ACC0;
			else if (r[1:0] == 2'd3) o.dst = bpf_pkg::D_POS;
			else o.dst = bpf_pkg::D_ACC;
		end else if (pc >= 5'd20 && pc < EVAL_END) begin
			r = pc - 5'd20;
			o.sel = bpf_pkg::M_TW;
			if (r < 5'd3) begin
				o.k = 2'd0;
				o.j = r[1:0];
			end else if (r < 5'd6) begin
				o.k = 2'd1;
				o.j = 2'(r - 5'd3);
			end else begin
				o.k = 2'd2;
				o.j = 2'(r - 5'd6);
			end
			if (o.j == 2'd0) o.dst = bpf_pkg::D_ACC0;
			else if (o.j == 2'd2) o.dst = bpf_pkg::D_TAN;
			else o.dst = bpf_pkg::D_ACC;
		end
		return o;
	endfunction

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid && in_action == bpf_pkg::ACT_TICK && stat.enabled) begin
					cmd.start = 1'b1;
					state_nx = ST_DIST;
				end
			end
			ST_DIST: begin
				cmd.op = '{sel: bpf_pkg::M_DIST, dst: bpf_pkg::D_DIST, j: 2'd0, k: 2'd0};
				state_nx = ST_LEN;
			end
			ST_LEN: begin
				cmd.op = '{sel: bpf_pkg::M_REM, dst: bpf_pkg::D_REM, j: 2'd0, k: 2'd0};
				cmd.len_latch = 1'b1;
				state_nx = ST_WAIT;
			end
			ST_WAIT: state_nx = ST_CMP;
			ST_CMP: begin
				if (stat.gt) begin
					cmd.walk_step = 1'b1;
					state_nx = ST_WRD;
				end else if (stat.len_zero) begin
					state_nx = ST_RDA;
				end else if (stat.back_full) begin
					cmd.p_zero = 1'b1;
					state_nx = ST_RDA;
				end else begin
					cmd.div_back = 1'b1;
					state_nx = ST_DIV;
				end
			end
			ST_WRD: state_nx = ST_WLD;
			ST_WLD: begin
				cmd.rem_load = 1'b1;
				state_nx = ST_WCHK;
			end
			ST_WCHK: begin
				if (stat.gt && !stat.steps_done) begin
					cmd.walk_step = 1'b1;
					state_nx = ST_WRD;
				end else if (stat.ge) begin
					cmd.p_max = 1'b1;
					state_nx = ST_RDA;
				end else begin
					cmd.div_fwd = 1'b1;
					state_nx = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) state_nx = ST_DIVF;
			end
			ST_DIVF: begin
				cmd.div_fin = 1'b1;
				state_nx = ST_RDA;
			end
			ST_RDA: state_nx = ST_RDB;
			ST_RDB: begin
				cmd.cap_a = 1'b1;
				cmd.rd_next = 1'b1;
				state_nx = ST_RDC;
			end
			ST_RDC: begin
				cmd.cap_b = 1'b1;
				state_nx = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.op = eval_op(pc_q);
				if (pc_q == EVAL_END) state_nx = ST_OUT;
			end
			ST_OUT: begin
				// hold the result until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q <= 5'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			pc_q <= (state_q == ST_EVAL) ? pc_q + 5'd1 : 5'd0;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end
endmodule

// ===== src/bpf_dp.sv =====
// Datapath: knot stores, config registers, shared multiplier, divider, results.
module bpf_dp #(
	parameter int MAX_KNOTS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_wdata,
	input  bpf_pkg::in_item_t   in_data,
	input  bpf_pkg::ctrl_cmd_t  cmd,
	output bpf_pkg::dp_stat_t   stat,
	output bpf_pkg::out_item_t  out_data
);
	localparam int AW = $clog2(MAX_KNOTS);

	logic [31:0] speed_q;
	logic        enabled_q;
	logic [5:0]  segcnt_q;
	logic [5:0]  cnt_c, cnt_q, seg_q, steps_q, seg_p1, seg_fix;
	logic [6:0]  seg_inc;
	logic [15:0] p_q, ts_q, quo_q;
	logic [16:0] s_c;
	logic [31:0] dist_q, rem_q, len_q, num_q, den_q, back_n;
	logic [32:0] s2_q, r2;
	logic [31:0] sq_q, q2_q;
	logic [30:0] b0_q, b1_q, b2_q, b3_q, bsel, wsel;
	logic [3:0]  dcnt_q;
	logic        mode_q, idx_ok, r2_ge;
	logic [95:0] p0_q, o0_q, i1_q, p1_q, pts_rd, inh_rd, outh_rd, knot_sel;
	logic [31:0] len_rd;
	logic signed [31:0] coord_c;
	logic signed [32:0] diff_c;
	logic signed [34:0] ma;
	logic signed [33:0] mb;
	logic signed [68:0] prod_q;
	logic signed [65:0] acc_q, sum_c;
	logic signed [35:0] sh_c;
	logic signed [37:0] t3_c;
	logic signed [31:0] tan_c;
	logic [50:0] tri_c;
	bpf_pkg::mul_op_t   op_q;
	logic signed [31:0] pos_q [3];
	logic signed [31:0] tan_q [3];
	bpf_pkg::out_item_t out_q;

	function automatic logic signed [31:0] pick(input logic [95:0] v, input logic [1:0] k);
		logic signed [31:0] r;
		unique case (k)
			2'd0: r = v[31:0];
			2'd1: r = v[63:32];
			default: r = v[95:64];
		endcase
		return r;
	endfunction

	// clamp the segment count to the usable range
	always_comb begin
		cnt_c = segcnt_q;
		if (segcnt_q == 6'd0) cnt_c = 6'd1;
		else if (int'(segcnt_q) > MAX_KNOTS - 1) cnt_c = 6'(MAX_KNOTS - 1);
	end

	assign seg_fix = (seg_q >= cnt_c) ? 6'd0 : seg_q;
	assign seg_inc = {1'b0, seg_q} + 7'd1;
	assign seg_p1  = seg_inc[5:0];
	assign s_c     = 17'h10000 - {1'b0, p_q};
	assign idx_ok  = int'(in_data.index) < MAX_KNOTS;

	bpf_ram #(.WIDTH(96), .DEPTH(MAX_KNOTS)) u_pts (
		.clk(clk),
		.we(cmd.accept && in_data.action == bpf_pkg::ACT_POINT && idx_ok),
		.waddr(AW'(in_data.index)),
		.wdata({in_data.vec_z, in_data.vec_y, in_data.vec_x}),
		.raddr(AW'(cmd.rd_next ? seg_p1 : seg_q)),
		.rdata(pts_rd)
	);
	bpf_ram #(.WIDTH(96), .DEPTH(MAX_KNOTS)) u_inh (
		.clk(clk),
		.we(cmd.accept && in_data.action == bpf_pkg::ACT_IN && idx_ok),
		.waddr(AW'(in_data.index)),
		.wdata({in_data.vec_z, in_data.vec_y, in_data.vec_x}),
		.raddr(AW'(seg_p1)),
		.rdata(inh_rd)
	);
	bpf_ram #(.WIDTH(96), .DEPTH(MAX_KNOTS)) u_outh (
		.clk(clk),
		.we(cmd.accept && in_data.action == bpf_pkg::ACT_OUT && idx_ok),
		.waddr(AW'(in_data.index)),
		.wdata({in_data.vec_z, in_data.vec_y, in_data.vec_x}),
		.raddr(AW'(seg_q)),
		.rdata(outh_rd)
	);
	bpf_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_len (
		.clk(clk),
		.we(cmd.accept && in_data.action == bpf_pkg::ACT_LEN && idx_ok),
		.waddr(AW'(in_data.index)),
		.wdata(in_data.seg_length),
		.raddr(AW'(seg_q)),
		.rdata(len_rd)
	);

	// operand selection for the shared multiplier
	always_comb begin
		unique case (cmd.op.j)
			2'd0: bsel = b0_q;
			2'd1: bsel = b1_q;
			2'd2: bsel = b2_q;
			default: bsel = b3_q;
		endcase
		unique case (cmd.op.j)
			2'd0: knot_sel = p0_q;
			2'd1: knot_sel = o0_q;
			2'd2: knot_sel = i1_q;
			default: knot_sel = p1_q;
		endcase
		coord_c = pick(knot_sel, cmd.op.k);
		unique case (cmd.op.j)
			2'd0: begin
				wsel = s2_q[32:2];
				diff_c = 33'(pick(o0_q, cmd.op.k)) - 33'(pick(p0_q, cmd.op.k));
			end
			2'd1: begin
				wsel = 31'(sq_q >> 1);
				diff_c = 33'(pick(i1_q, cmd.op.k)) - 33'(pick(o0_q, cmd.op.k));
			end
			default: begin
				wsel = {1'b0, q2_q[31:2]};
				diff_c = 33'(pick(p1_q, cmd.op.k)) - 33'(pick(i1_q, cmd.op.k));
			end
		endcase
		unique case (cmd.op.sel)
			bpf_pkg::M_DIST: begin ma = {3'd0, speed_q}; mb = {18'd0, ts_q}; end
			bpf_pkg::M_REM:  begin ma = {3'd0, len_rd};  mb = {17'd0, s_c}; end
			bpf_pkg::M_S2:   begin ma = {18'd0, s_c};    mb = {17'd0, s_c}; end
			bpf_pkg::M_SQ:   begin ma = {18'd0, s_c};    mb = {18'd0, p_q}; end
			bpf_pkg::M_Q2:   begin ma = {19'd0, p_q};    mb = {18'd0, p_q}; end
			bpf_pkg::M_S3:   begin ma = {2'd0, s2_q};    mb = {17'd0, s_c}; end
			bpf_pkg::M_T1:   begin ma = {2'd0, s2_q};    mb = {18'd0, p_q}; end
			bpf_pkg::M_T2:   begin ma = {3'd0, q2_q};    mb = {17'd0, s_c}; end
			bpf_pkg::M_Q3:   begin ma = {3'd0, q2_q};    mb = {18'd0, p_q}; end
			bpf_pkg::M_PB:   begin ma = {4'd0, bsel};    mb = {{2{coord_c[31]}}, coord_c}; end
			bpf_pkg::M_TW:   begin ma = {4'd0, wsel};    mb = {diff_c[32], diff_c}; end
			default:         begin ma = '0;              mb = '0; end
		endcase
	end

	assign sum_c  = acc_q + prod_q[65:0];
	assign sh_c   = sum_c[65:30];
	assign t3_c   = {sh_c[35], sh_c, 1'b0} + {{2{sh_c[35]}}, sh_c};
	assign tri_c  = {prod_q[49:0], 1'b0} + {1'b0, prod_q[49:0]};
	assign back_n = rem_q - dist_q;
	assign r2     = {num_q, 1'b0};
	assign r2_ge  = r2 >= {1'b0, den_q};

	// saturate three times the floored derivative sum
	always_comb begin
		if (t3_c > 38'sd2147483647) tan_c = 32'sh7FFFFFFF;
		else if (t3_c < -38'sd2147483648) tan_c = 32'sh80000000;
		else tan_c = t3_c[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= 32'd0;
			enabled_q <= 1'b0;
			segcnt_q <= 6'd1;
			seg_q <= 6'd0;
			p_q <= 16'd0;
			op_q <= '{sel: bpf_pkg::M_NONE, dst: bpf_pkg::D_NONE, j: 2'd0, k: 2'd0};
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					bpf_pkg::CFG_SPEED:   speed_q <= cfg_wdata;
					bpf_pkg::CFG_ENABLED: enabled_q <= cfg_wdata[0];
					bpf_pkg::CFG_SEGCNT:  segcnt_q <= cfg_wdata[5:0];
					default: ;
				endcase
			end
			op_q <= cmd.op;
			if (cmd.start) seg_q <= seg_fix;
			else if (cmd.walk_step) seg_q <= (seg_inc >= {1'b0, cnt_q}) ? 6'd0 : seg_p1;
			if (cmd.p_max) p_q <= 16'hFFFF;
			else if (cmd.p_zero) p_q <= 16'd0;
			else if (cmd.div_fin) begin
				if (!mode_q) p_q <= quo_q;
				else if (quo_q == 16'd0) p_q <= 16'hFFFF;
				else p_q <= 16'(17'h10000 - {1'b0, quo_q});
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
		if (cmd.start) begin
			cnt_q <= cnt_c;
			ts_q <= in_data.time_step;
			steps_q <= 6'd0;
		end
		if (cmd.len_latch) len_q <= len_rd;
		if (cmd.rem_load) rem_q <= len_rd;
		if (cmd.walk_step) begin
			dist_q <= dist_q - rem_q;
			steps_q <= steps_q + 6'd1;
		end
		unique case (op_q.dst)
			bpf_pkg::D_DIST: dist_q <= prod_q[47:16];
			bpf_pkg::D_REM:  rem_q <= prod_q[47:16];
			bpf_pkg::D_S2:   s2_q <= prod_q[32:0];
			bpf_pkg::D_SQ:   sq_q <= prod_q[31:0];
			bpf_pkg::D_Q2:   q2_q <= prod_q[31:0];
			bpf_pkg::D_B0:   b0_q <= prod_q[48:18];
			bpf_pkg::D_B1:   b1_q <= tri_c[48:18];
			bpf_pkg::D_B2:   b2_q <= tri_c[48:18];
			bpf_pkg::D_B3:   b3_q <= prod_q[48:18];
			bpf_pkg::D_ACC0: acc_q <= prod_q[65:0];
			bpf_pkg::D_ACC:  acc_q <= sum_c;
			bpf_pkg::D_POS: begin
				unique case (op_q.k)
					2'd0: pos_q[0] <= sum_c[61:30];
					2'd1: pos_q[1] <= sum_c[61:30];
					default: pos_q[2] <= sum_c[61:30];
				endcase
			end
			bpf_pkg::D_TAN: begin
				unique case (op_q.k)
					2'd0: tan_q[0] <= tan_c;
					2'd1: tan_q[1] <= tan_c;
					default: tan_q[2] <= tan_c;
				endcase
			end
			default: ;
		endcase
		// restoring divide, one quotient bit a cycle, numerator below divisor
		if (cmd.div_fwd) begin
			num_q <= dist_q;
			den_q <= rem_q;
			mode_q <= 1'b0;
			dcnt_q <= 4'd0;
		end else if (cmd.div_back) begin
			num_q <= back_n;
			den_q <= len_q;
			mode_q <= 1'b1;
			dcnt_q <= 4'd0;
		end else if (cmd.div_step) begin
			num_q <= r2_ge ? 32'(r2 - {1'b0, den_q}) : r2[31:0];
			quo_q <= {quo_q[14:0], r2_ge};
			dcnt_q <= dcnt_q + 4'd1;
		end
		if (cmd.cap_a) begin
			p0_q <= pts_rd;
			o0_q <= outh_rd;
			i1_q <= inh_rd;
		end
		if (cmd.cap_b) p1_q <= pts_rd;
		if (cmd.load_out) begin
			out_q.pos_x <= pos_q[0];
			out_q.pos_y <= pos_q[1];
			out_q.pos_z <= pos_q[2];
			out_q.tan_x <= tan_q[0];
			out_q.tan_y <= tan_q[1];
			out_q.tan_z <= tan_q[2];
			out_q.segment_now <= seg_q;
			out_q.param_now <= p_q;
		end
	end

	assign stat.enabled    = enabled_q;
	assign stat.gt         = dist_q > rem_q;
	assign stat.ge         = dist_q >= rem_q;
	assign stat.len_zero   = len_q == 32'd0;
	assign stat.back_full  = back_n >= len_q;
	assign stat.steps_done = steps_q == cnt_q;
	assign stat.div_last   = dcnt_q == 4'd15;
	assign out_data        = out_q;
endmodule

// ===== src/bezier_path_follower.sv =====
// Cubic Bezier path follower: arc-length stepping and curve evaluation.
//
// in_ch takes one request at a time: knot point, in-handle, out-handle
// and segment length writes complete in the cycle they are taken.
// A tick request, while enabled, advances the follower by speed*time_step
// along the path and produces one out_ch request with position, tangent,
// segment and parameter; a disabled tick produces nothing.
// A tick's run time is set mostly by the shared multiplier (about 30
// products in turn), the rest by a 16-step restoring divider and one
// length-memory read per walked segment.
// in_ch stays ready while a finished result waits on out_ch; a further tick
// then runs and holds its result internally until out_ch takes the previous
// one. The user must write configuration (speed, enabled, segment_count)
// through cfg_we/cfg_index/cfg_wdata only while idle; it is not enforced.
// Reset clears the follower to segment 0, parameter 0, speed 0, disabled,
// one segment; knot and length memories hold nothing until written.
module bezier_path_follower #(
	parameter int MAX_KNOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	bpf_in_if.sink      in_ch,
	bpf_out_if.source   out_ch,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);
	bpf_pkg::ctrl_cmd_t cmd;
	bpf_pkg::dp_stat_t  stat;

	bpf_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.in_action(in_ch.data.action),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.cmd(cmd),
		.stat(stat)
	);

	bpf_dp #(.MAX_KNOTS(MAX_KNOTS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_data(in_ch.data),
		.cmd(cmd),
		.stat(stat),
		.out_data(out_ch.data)
	);
endmodule

// ===== src/bpf_chk.sv =====
// Port-level checker for the path follower, bound to the top level.
module bpf_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [2:0]         in_action,
	input logic               out_valid,
	input logic               out_ready,
	input bpf_pkg::out_item_t out_data
);
	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// writes and other non-tick requests leave in_ready set in the next cycle
	a_write_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_action != bpf_pkg::ACT_TICK |=> in_ready)
		else $error("busy after write request");

	// a busy tick cannot finish while the output is stalled
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready && out_valid && !out_ready |=> !in_ready)
		else $error("returned idle with output blocked");

	// a new result appears only as a tick completes
	a_result_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready && $past(!in_ready))
		else $error("result without finished tick");
endmodule

bind bezier_path_follower bpf_chk u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_ch.valid),
	.in_ready(in_ch.ready),
	.in_action(in_ch.data.action),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_data(out_ch.data)
);
